[rtl/arc_pkg.sv]
// Package for the address resolution cache: operation and status codes,
// the input, command, result and table entry types. No dependencies.
package arc_pkg;

	typedef enum logic [2:0] {
		OP_LOOKUP  = 3'd0,
		OP_ADD     = 3'd1,
		OP_ENQUEUE = 3'd2,
		OP_DEQUEUE = 3'd3,
		OP_CLEAR   = 3'd4,
		OP_NOP     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_ENT  = 2'd1,
		B_EXEC = 2'd2
	} bstate_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  net_address;
		logic [47:0] hw_address;
		logic        hw_address_given;
		logic [3:0]  port_number;
		logic        port_given;
		logic [15:0] packet_handle;
	} item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  addr;
		logic        in_table;
		logic [47:0] hw;
		logic        hw_given;
		logic [3:0]  port;
		logic        port_given;
		logic [15:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] found_hw_address;
		logic        hw_address_known;
		logic [3:0]  found_port;
		logic        port_known;
		logic [15:0] released_handle;
	} result_t;

	typedef struct packed {
		logic [47:0] hw;
		logic        hw_known;
		logic [3:0]  port;
		logic        port_known;
		logic [3:0]  head;
		logic [4:0]  count;
	} entry_t;

endpackage

[rtl/arc_fifo.sv]
// Two-entry queue of any packed type, used between the front and back
// parts and on the result side. Depends on nothing.
module arc_fifo #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	output logic full,
	input  logic rd,
	output T     rdata,
	output logic empty
);
	T           mem [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule

[rtl/arc_front.sv]
// Front part: accepts input beats and classifies them into commands.
// Depends on arc_pkg.
module arc_front #(
	parameter int TABLE_ENTRIES = 256,
	parameter int HANDLE_BITS   = 16,
	parameter int PORT_COUNT    = 16
) (
	input  logic          push,
	output logic          full,
	input  arc_pkg::item_t item,
	output logic          cmd_wr,
	output arc_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import arc_pkg::*;

	localparam logic [15:0] HMASK = (HANDLE_BITS >= 16) ? 16'hFFFF :
		16'((1 << HANDLE_BITS) - 1);

	assign full   = cmd_full;
	assign cmd_wr = push && !cmd_full;

	always_comb begin
		cmd.addr       = item.net_address;
		cmd.in_table   = ({1'b0, item.net_address} < 9'(TABLE_ENTRIES));
		cmd.hw         = item.hw_address;
		cmd.hw_given   = item.hw_address_given;
		cmd.port       = item.port_number;
		cmd.port_given = item.port_given && ({5'd0, item.port_number} < 9'(PORT_COUNT));
		cmd.handle     = item.packet_handle & HMASK;
		case (item.operation)
			OP_LOOKUP:  cmd.op = OP_LOOKUP;
			OP_ADD:     cmd.op = OP_ADD;
			OP_ENQUEUE: cmd.op = OP_ENQUEUE;
			OP_DEQUEUE: cmd.op = OP_DEQUEUE;
			OP_CLEAR:   cmd.op = OP_CLEAR;
			default:    cmd.op = OP_NOP;
		endcase
	end
endmodule

[rtl/arc_back.sv]
// Back part: carries out one command at a time against the entry table and
// the pending handle memory, and pushes one result. Depends on arc_pkg.
module arc_back #(
	parameter int TABLE_ENTRIES = 256,
	parameter int QUEUE_DEPTH   = 4,
	parameter int HANDLE_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  arc_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output arc_pkg::result_t res
);
	import arc_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int PW = $clog2(TABLE_ENTRIES * QUEUE_DEPTH);
	localparam int SW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
	localparam logic [4:0] QD = 5'(QUEUE_DEPTH);

	entry_t                 ent_mem [TABLE_ENTRIES];
	logic [SW-1:0]          pend_mem [TABLE_ENTRIES * QUEUE_DEPTH];
	logic [TABLE_ENTRIES-1:0] valid_q;
	bstate_t                state_q, state_d;
	cmd_t                   cmd_q;
	entry_t                 ent_q, ent_wd;
	logic [SW-1:0]          pend_q;
	logic [AW-1:0]          ra, a;
	logic                   present, ent_we, pend_we, set_valid, clear_all;
	logic [4:0]             sum, slot, next_head;
	logic [PW-1:0]          pr_idx, pw_idx;

	assign ra      = cmd.in_table ? cmd.addr[AW-1:0] : '0;
	assign a       = cmd_q.in_table ? cmd_q.addr[AW-1:0] : '0;
	assign present = cmd_q.in_table && valid_q[a];
	assign sum     = {1'b0, ent_q.head} + ent_q.count;
	assign slot    = (sum >= QD) ? sum - QD : sum;
	assign next_head = ({1'b0, ent_q.head} + 5'd1 == QD) ? 5'd0 : {1'b0, ent_q.head} + 5'd1;
	assign pr_idx  = PW'(a) * PW'(QUEUE_DEPTH) + PW'(ent_q.head);
	assign pw_idx  = PW'(a) * PW'(QUEUE_DEPTH) + PW'(slot);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		ent_we    = 1'b0;
		pend_we   = 1'b0;
		set_valid = 1'b0;
		clear_all = 1'b0;
		ent_wd    = ent_q;
		res       = '0;
		res.status = ST_MISS;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					state_d = B_ENT;
				end
			end
			B_ENT: state_d = B_EXEC;
			B_EXEC: begin
				res_push = 1'b1;
				state_d  = B_IDLE;
				case (cmd_q.op)
					OP_LOOKUP: begin
						if (present) begin
							res.status           = ST_OK;
							res.hw_address_known = ent_q.hw_known;
							res.port_known       = ent_q.port_known;
							if (ent_q.hw_known) res.found_hw_address = ent_q.hw;
							if (ent_q.port_known) res.found_port = ent_q.port;
						end
					end
					OP_ADD: begin
						if (cmd_q.in_table) begin
							if (!present) ent_wd = '0;
							if (cmd_q.hw_given) begin
								ent_wd.hw       = cmd_q.hw;
								ent_wd.hw_known = 1'b1;
							end
							if (cmd_q.port_given) begin
								ent_wd.port       = cmd_q.port;
								ent_wd.port_known = 1'b1;
							end
							ent_we     = 1'b1;
							set_valid  = 1'b1;
							res.status = ST_OK;
						end
					end
					OP_ENQUEUE: begin
						if (present) begin
							if (ent_q.count >= QD) begin
								res.status = ST_FULL;
							end else begin
								pend_we      = 1'b1;
								ent_wd.count = ent_q.count + 5'd1;
								ent_we       = 1'b1;
								res.status   = ST_OK;
							end
						end
					end
					OP_DEQUEUE: begin
						if (present && ent_q.count != 5'd0) begin
							res.released_handle = 16'(pend_q);
							ent_wd.head  = next_head[3:0];
							ent_wd.count = ent_q.count - 5'd1;
							ent_we       = 1'b1;
							res.status   = ST_OK;
						end
					end
					OP_CLEAR: begin
						clear_all  = 1'b1;
						res.status = ST_OK;
					end
					default: ;
				endcase
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[a] <= ent_wd;
		if (cmd_pop) ent_q <= ent_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pw_idx] <= cmd_q.handle[SW-1:0];
		if (state_q == B_ENT) pend_q <= pend_mem[pr_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear_all) valid_q <= '0;
			else if (set_valid) valid_q[a] <= 1'b1;
		end
	end
endmodule

[rtl/address_resolution_cache_pending_queue.sv]
// Address resolution cache with per-entry pending handle queues.
// A beat goes through the command queue to the back part, which reads the
// entry memory, then the pending memory, then writes back and pushes the
// result into the result queue; it starts no new item before that is done.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// Depends on arc_pkg, arc_fifo, arc_front and arc_back.
module address_resolution_cache_pending_queue #(
	parameter int TABLE_ENTRIES = 256,
	parameter int QUEUE_DEPTH   = 4,
	parameter int HANDLE_BITS   = 16,
	parameter int PORT_COUNT    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  arc_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output arc_pkg::result_t result
);
	import arc_pkg::*;

	// Classified commands wait in a short queue so the front keeps taking
	// beats while the back works through its memory sequence.
	logic    cmd_wr, cmd_full, cmd_empty, cmd_pop;
	cmd_t    cmd_in, cmd_out;
	// Results wait in their own queue so a stalled consumer does not hold
	// the back part in the middle of an item.
	logic    res_push, res_full;
	result_t res;

	arc_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.HANDLE_BITS  (HANDLE_BITS),
		.PORT_COUNT   (PORT_COUNT)
	) u_front (
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_wr  (cmd_wr),
		.cmd     (cmd_in),
		.cmd_full(cmd_full)
	);

	arc_fifo #(.T(cmd_t)) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (cmd_wr),
		.wdata (cmd_in),
		.full  (cmd_full),
		.rd    (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	arc_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	arc_fifo #(.T(result_t)) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.full  (res_full),
		.rd    (pop),
		.rdata (result),
		.empty (empty)
	);
endmodule
